### src/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies something on the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

// Check that a condition holds on every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

### src/scic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scic_pkg
// Shared types and codes of the smart-card interface controller.
// ----------------------------------------------------------------------------
package scic_pkg;

  localparam logic [3:0] OP_CTRL_WR  = 4'd0;
  localparam logic [3:0] OP_CTRL_RD  = 4'd1;
  localparam logic [3:0] OP_RX_RD    = 4'd2;
  localparam logic [3:0] OP_COUNT_RD = 4'd3;
  localparam logic [3:0] OP_TX_WR    = 4'd4;
  localparam logic [3:0] OP_TXFC_WR  = 4'd5;
  localparam logic [3:0] OP_RXFC_WR  = 4'd6;
  localparam logic [3:0] OP_CARD_BYTE = 4'd7;
  localparam logic [3:0] OP_CARD_DONE = 4'd8;
  localparam logic [3:0] OP_CLOCK    = 4'd9;
  localparam logic [3:0] OP_TICK     = 4'd10;

  localparam logic [2:0] KIND_ACK      = 3'd0;
  localparam logic [2:0] KIND_READ     = 3'd1;
  localparam logic [2:0] KIND_IRQ      = 3'd2;
  localparam logic [2:0] KIND_CARD_BYTE = 3'd3;
  localparam logic [2:0] KIND_ACTIVATE = 3'd4;

  localparam logic [7:0] IRQ_TX = 8'h10;
  localparam logic [7:0] IRQ_RX = 8'h40;
  localparam logic [7:0] IRQ_NONE = 8'h00;

  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_CARD    = 2'd1;
  localparam logic [1:0] REG_TICKS   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RXRD,
    ST_FLUSH_RD,
    ST_FLUSH_OUT,
    ST_EMIT
  } state_t;

endpackage

### src/sim_card_interface_controller.sv
`timescale 1ns / 1ps
// Timing: an item's first result is registered on acceptance; a popping rx
//   read waits in ST_RXRD for ring data, a flush passes ST_FLUSH_RD and sends
//   one transmit memory byte per cycle. Throughput: one item per cycle for items
//   with one result and no memory read; receiver stalls hold both rates.
// Reset: rst_n is synchronous and active low; it clears all control state.
//   The queue memories are not cleared; fill pointers track valid entries.
// ----------------------------------------------------------------------------
// sim_card_interface_controller
// Register-level smart-card interface controller with rx ring and tx queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sim_card_interface_controller
  import scic_pkg::*;
#(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_op,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [7:0]  out_int_status,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int RXA = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RXL = $clog2(RX_DEPTH + 1);
  localparam int TXA = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int TXL = $clog2(TX_DEPTH + 1);
  localparam logic [RXL-1:0] RX_FULL = RXL'(RX_DEPTH);
  localparam logic [TXL-1:0] TX_FULL = TXL'(TX_DEPTH);
  localparam logic [RXA-1:0] RX_LAST = RXA'(RX_DEPTH - 1);

  // Configuration registers
  logic        enabled_r, card_present_r;
  logic [15:0] char_ticks_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // Controller state
  logic [7:0]     ctrl_reg_r, ctrl_reg_nxt;
  logic [RXA-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [RXL-1:0] rx_level_r, rx_level_nxt, rx_snap_r, rx_snap_nxt;
  logic           holding_r, holding_nxt;
  logic [7:0]     irq_r, irq_nxt;
  logic           txe_r, txe_nxt;
  logic [TXL-1:0] tx_level_r, tx_level_nxt;
  logic [7:0]     rxfc_r, rxfc_nxt, txfc_r, txfc_nxt;
  logic           clk_on_r, clk_on_nxt;
  logic           armed_r, armed_nxt;
  logic [15:0]    left_r, left_nxt;
  logic           await_r, await_nxt, await_flush_r, await_flush_nxt;

  // Sequencer and output register
  state_t         state_r, state_nxt;
  logic [TXL-1:0] fl_cnt_r, fl_cnt_nxt, fl_num_r, fl_num_nxt;
  logic [TXL-1:0] fl_prev;
  logic           ov_r, ov_nxt;
  logic [2:0]     ok_r, ok_nxt;
  logic [7:0]     oval_r, oval_nxt, oirq_r, oirq_nxt;
  logic           olast_r, olast_nxt;

  // Memory ports
  logic           rx_we, tx_we;
  logic [7:0]     rx_rdata, tx_rdata;
  logic [TXA-1:0] tx_raddr;

  logic accept, out_free, active, pop_fire;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_ENABLED: cfg_prdata = {31'd0, enabled_r};
      REG_CARD:    cfg_prdata = {31'd0, card_present_r};
      REG_TICKS:   cfg_prdata = {16'd0, char_ticks_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r      <= 1'b1;
      card_present_r <= 1'b1;
      char_ticks_r   <= 16'd1;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
      case (cfg_idx)
        REG_ENABLED: enabled_r      <= cfg_pwdata[0];
        REG_CARD:    card_present_r <= cfg_pwdata[0];
        REG_TICKS:   char_ticks_r   <= cfg_pwdata[15:0];
        default:     ;
      endcase
    end
  end

  // Receive ring and transmit queue memories
  scic_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_tail_r), .wdata(in_data),
    .raddr(rx_head_r), .rdata(rx_rdata)
  );
  scic_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_level_r[TXA-1:0]), .wdata(in_data),
    .raddr(tx_raddr), .rdata(tx_rdata)
  );

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign active   = enabled_r && clk_on_r && ctrl_reg_r[7];
  assign rx_we    = accept && in_op == OP_CARD_BYTE && rx_level_r < RX_FULL;
  assign tx_we    = accept && in_op == OP_TX_WR && active && tx_level_r < TX_FULL;
  // The read address stays one ahead of the byte being sent; hold it on the
  // waiting byte while the receiver stalls.
  assign fl_prev  = fl_cnt_r - 1'b1;
  assign tx_raddr = (state_r == ST_FLUSH_OUT && !out_free) ? fl_prev[TXA-1:0]
                                                           : fl_cnt_r[TXA-1:0];
  assign pop_fire = holding_r && rx_level_r != '0;

  assign out_valid      = ov_r;
  assign out_kind       = ok_r;
  assign out_value      = oval_r;
  assign out_int_status = oirq_r;
  assign out_last       = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_reg_r <= '0; rx_head_r <= '0; rx_tail_r <= '0; rx_level_r <= '0;
      rx_snap_r <= '0; holding_r <= 1'b0; irq_r <= '0; txe_r <= 1'b0;
      tx_level_r <= '0; rxfc_r <= '0; txfc_r <= '0; clk_on_r <= 1'b0;
      armed_r <= 1'b0; left_r <= '0; await_r <= 1'b0; await_flush_r <= 1'b0;
      state_r <= ST_IDLE; fl_cnt_r <= '0; fl_num_r <= '0; ov_r <= 1'b0;
    end else begin
      ctrl_reg_r <= ctrl_reg_nxt; rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt; rx_level_r <= rx_level_nxt;
      rx_snap_r <= rx_snap_nxt; holding_r <= holding_nxt; irq_r <= irq_nxt;
      txe_r <= txe_nxt; tx_level_r <= tx_level_nxt; rxfc_r <= rxfc_nxt;
      txfc_r <= txfc_nxt; clk_on_r <= clk_on_nxt; armed_r <= armed_nxt;
      left_r <= left_nxt; await_r <= await_nxt; await_flush_r <= await_flush_nxt;
      state_r <= state_nxt; fl_cnt_r <= fl_cnt_nxt; fl_num_r <= fl_num_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt; oval_r <= oval_nxt; oirq_r <= oirq_nxt; olast_r <= olast_nxt;
  end

  always_comb begin
    logic sched, resp, txc, arm;
    ctrl_reg_nxt = ctrl_reg_r; rx_head_nxt = rx_head_r; rx_tail_nxt = rx_tail_r;
    rx_level_nxt = rx_level_r; rx_snap_nxt = rx_snap_r; holding_nxt = holding_r;
    irq_nxt = irq_r; txe_nxt = txe_r; tx_level_nxt = tx_level_r;
    rxfc_nxt = rxfc_r; txfc_nxt = txfc_r; clk_on_nxt = clk_on_r;
    armed_nxt = armed_r; left_nxt = left_r; await_nxt = await_r;
    await_flush_nxt = await_flush_r; state_nxt = state_r;
    fl_cnt_nxt = fl_cnt_r; fl_num_nxt = fl_num_r;
    ov_nxt = ov_r && !out_ready;
    ok_nxt = ok_r; oval_nxt = oval_r; oirq_nxt = oirq_r; olast_nxt = olast_r;
    sched = 1'b0; resp = 1'b0; txc = 1'b0; arm = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Default result: single ack, carrying status after the update
          ok_nxt = KIND_ACK; oval_nxt = 8'd0; olast_nxt = 1'b1;
          ov_nxt = 1'b1;
          case (in_op)
            OP_CTRL_WR: begin
              ctrl_reg_nxt = in_data;
              if (enabled_r && clk_on_r && in_data[7] && !ctrl_reg_r[7]) begin
                rx_head_nxt = '0; rx_tail_nxt = '0; rx_level_nxt = '0;
                holding_nxt = 1'b0; irq_nxt = IRQ_NONE; txe_nxt = 1'b0;
                tx_level_nxt = '0;
                if (card_present_r) begin
                  ok_nxt = KIND_ACTIVATE;
                  await_nxt = 1'b1; await_flush_nxt = 1'b0; rx_snap_nxt = '0;
                end
              end
            end
            OP_CTRL_RD: begin
              ok_nxt = KIND_READ;
              oval_nxt = active ? (ctrl_reg_r | 8'h40) : ctrl_reg_r;
            end
            OP_RX_RD: begin
              ok_nxt = KIND_READ;
              if (pop_fire) begin
                // Wait in ST_RXRD for the ring read data
                ov_nxt = 1'b0;
                state_nxt = ST_RXRD;
                rx_head_nxt = (rx_head_r == RX_LAST) ? '0 : rx_head_r + 1'b1;
                rx_level_nxt = rx_level_r - 1'b1;
                holding_nxt = 1'b0;
                if (rx_level_r != RXL'(1)) arm = 1'b1;
                else begin armed_nxt = 1'b0; left_nxt = '0; end
              end
            end
            OP_COUNT_RD: begin
              ok_nxt = KIND_READ;
              oval_nxt = {7'd0, pop_fire};
            end
            OP_TX_WR: begin
              if (tx_we) tx_level_nxt = tx_level_r + 1'b1;
            end
            OP_TXFC_WR: begin
              txfc_nxt = in_data;
              if (active && in_data == 8'd0 && txfc_r != 8'd0) begin
                rx_snap_nxt = rx_level_r;
                tx_level_nxt = '0;
                if (card_present_r) begin
                  await_nxt = 1'b1; await_flush_nxt = 1'b1;
                  if (tx_level_r != '0) begin
                    ov_nxt = 1'b0;
                    fl_cnt_nxt = '0; fl_num_nxt = tx_level_r;
                    state_nxt = ST_FLUSH_RD;
                  end
                end else begin
                  sched = 1'b1; txc = 1'b1;
                end
              end
            end
            OP_RXFC_WR: rxfc_nxt = in_data;
            OP_CARD_BYTE: begin
              if (rx_we) begin
                rx_tail_nxt = (rx_tail_r == RX_LAST) ? '0 : rx_tail_r + 1'b1;
                rx_level_nxt = rx_level_r + 1'b1;
              end
            end
            OP_CARD_DONE: begin
              if (await_r) begin
                await_nxt = 1'b0; sched = 1'b1;
                txc = await_flush_r;
                resp = await_flush_r ? (rx_level_r != rx_snap_r) : 1'b1;
              end
            end
            OP_CLOCK: begin
              if (in_data[0] != clk_on_r) begin
                clk_on_nxt = in_data[0];
                if (!in_data[0]) begin armed_nxt = 1'b0; left_nxt = '0; end
                else if (txe_r || (!holding_r && rx_level_r != '0)) arm = 1'b1;
              end
            end
            OP_TICK: begin
              if (armed_r) begin
                if (left_r > 16'd1) left_nxt = left_r - 1'b1;
                else begin
                  armed_nxt = 1'b0; left_nxt = '0;
                  if (enabled_r && clk_on_r) begin
                    if (txe_r) begin
                      txe_nxt = 1'b0; irq_nxt = irq_r | IRQ_TX;
                      ok_nxt = KIND_IRQ; arm = 1'b1;
                    end else if (rx_level_r != '0) begin
                      holding_nxt = 1'b1; irq_nxt = irq_r | IRQ_RX;
                      ok_nxt = KIND_IRQ;
                    end
                  end
                end
              end
            end
            default: ;
          endcase
          // Schedule the next interrupt after a response or transmit completion
          if (sched) begin
            if (resp) begin
              holding_nxt = 1'b0; txe_nxt = txc;
              if (txc || rx_level_r != '0) arm = 1'b1;
            end else if (txc && !txe_r) begin
              txe_nxt = 1'b1; arm = 1'b1;
            end
          end
          if (arm) begin armed_nxt = 1'b1; left_nxt = char_ticks_r; end
          oirq_nxt = irq_nxt;
        end
      end
      ST_RXRD: begin
        ok_nxt = KIND_READ; oval_nxt = rx_rdata; oirq_nxt = irq_r;
        olast_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = ST_IDLE;
      end
      ST_FLUSH_RD: begin
        // Issue the first queue read
        fl_cnt_nxt = fl_cnt_r + 1'b1;
        state_nxt = ST_FLUSH_OUT;
      end
      ST_FLUSH_OUT: begin
        if (out_free) begin
          ok_nxt = KIND_CARD_BYTE; oval_nxt = tx_rdata; oirq_nxt = irq_r;
          ov_nxt = 1'b1;
          olast_nxt = (fl_cnt_r == fl_num_r);
          if (fl_cnt_r == fl_num_r) state_nxt = ST_IDLE;
          else fl_cnt_nxt = fl_cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_rx_bound, clk, rst_n, 1'b1, rx_level_r <= RX_FULL,
    "rx level beyond depth")
  `ASSERT_ALWAYS(a_tx_bound, clk, rst_n, tx_level_r <= TX_FULL,
    "tx level beyond depth")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_value) && $stable(out_kind), "result dropped")
  `ASSERT_ALWAYS(a_idle_ready, clk, rst_n,
    !in_ready || state_r == ST_IDLE, "input taken while busy")
endmodule

### src/scic_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scic_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module scic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### verif/tb_sim_card_interface_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sim_card_interface_controller
// Self-checking bench: random bus, card and tick traffic against a local
// prediction of the controller, with config changes between phases.
// ----------------------------------------------------------------------------
module tb_sim_card_interface_controller;
  import scic_pkg::*;

  localparam int RXD = 16;
  localparam int TXD = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] status;
    logic       last;
  } res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_op;
  logic [7:0]  in_data;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_value;
  logic [7:0]  out_int_status;
  logic        out_last;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sim_card_interface_controller #(.RX_DEPTH(RXD), .TX_DEPTH(TXD)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_value(out_value), .out_int_status(out_int_status), .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Predicted controller state
  logic        m_en_cfg, m_card;
  logic [15:0] m_ticks;
  logic [7:0]  m_ctrl;
  logic [7:0]  m_rxq [RXD];
  int          m_rx_rd_idx, m_rx_wr_idx, m_rx_level;
  logic        m_holding;
  logic [7:0]  m_irq;
  logic        m_tx_pend;
  logic [7:0]  m_txq [TXD];
  int          m_tx_level;
  logic [7:0]  m_txfc;
  logic        m_clk_on, m_armed;
  int          m_left;
  logic        m_awaiting, m_await_flush;
  int          m_snap;

  item_t pending_items[$];
  res_t  expected_results[$];

  int  mismatches;
  bit  failed;
  int  idle_pct;       // chance in percent of an idle cycle on each side
  bit  rx_hold;        // receiver held off for a long stretch
  int  rx_hold_left;
  bit  stim_done;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void add_result(logic [2:0] kind, logic [7:0] value);
    res_t r;
    r.kind = kind;
    r.value = value;
    r.status = m_irq;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic bit ctl_active();
    return m_en_cfg && m_clk_on && m_ctrl[7];
  endfunction

  function automatic void arm_char_timer();
    m_armed = 1'b1;
    m_left = m_ticks;
  endfunction

  function automatic void schedule_delivery(bit tx_done, bit response);
    if (response) begin
      m_holding = 1'b0;
      m_tx_pend = tx_done;
    end else if (tx_done && !m_tx_pend) begin
      m_tx_pend = 1'b1;
    end else begin
      return;
    end
    if (m_tx_pend || (response && m_rx_level != 0)) arm_char_timer();
  endfunction

  function automatic int char_timer_fire();
    if (!m_en_cfg || !m_clk_on) return 0;
    if (m_tx_pend) begin
      m_tx_pend = 1'b0;
      m_irq |= IRQ_TX;
      add_result(KIND_IRQ, 8'h00);
      arm_char_timer();
      return 1;
    end else if (m_rx_level != 0) begin
      m_holding = 1'b1;
      m_irq |= IRQ_RX;
      add_result(KIND_IRQ, 8'h00);
      return 1;
    end
    return 0;
  endfunction

  // Work out the results of one accepted transaction
  function automatic void predict_controller(item_t it);
    int   n;
    bit   act;
    logic [7:0] v;
    logic [7:0] old;
    bit   en;
    res_t r;
    n = 0;
    case (it.op)
      OP_CTRL_WR: begin
        act = m_en_cfg && m_clk_on && it.data[7] && !m_ctrl[7];
        m_ctrl = it.data;
        if (act) begin
          m_rx_rd_idx = 0; m_rx_wr_idx = 0; m_rx_level = 0;
          m_holding = 1'b0; m_irq = IRQ_NONE; m_tx_pend = 1'b0; m_tx_level = 0;
          if (m_card) begin
            add_result(KIND_ACTIVATE, 8'h00); n++;
            m_awaiting = 1'b1; m_await_flush = 1'b0; m_snap = m_rx_level;
          end else begin
            schedule_delivery(1'b0, 1'b0);
          end
        end
      end
      OP_CTRL_RD: begin
        v = m_ctrl;
        if (ctl_active()) v |= 8'h40;
        add_result(KIND_READ, v); n++;
      end
      OP_RX_RD: begin
        v = 8'h00;
        if (m_holding && m_rx_level != 0) begin
          v = m_rxq[m_rx_rd_idx];
          m_rx_rd_idx = (m_rx_rd_idx + 1 >= RXD) ? 0 : m_rx_rd_idx + 1;
          m_rx_level--;
          m_holding = 1'b0;
          if (m_rx_level != 0) arm_char_timer();
          else begin m_armed = 1'b0; m_left = 0; end
        end
        add_result(KIND_READ, v); n++;
      end
      OP_COUNT_RD: begin
        add_result(KIND_READ, (m_holding && m_rx_level != 0) ? 8'd1 : 8'd0); n++;
      end
      OP_TX_WR: begin
        if (ctl_active() && m_tx_level < TXD) begin
          m_txq[m_tx_level] = it.data;
          m_tx_level++;
        end
      end
      OP_TXFC_WR: begin
        old = m_txfc;
        m_txfc = it.data;
        if (ctl_active() && it.data == 8'h00 && old != 8'h00) begin
          m_snap = m_rx_level;
          if (m_card) begin
            for (int i = 0; i < m_tx_level; i++) begin
              add_result(KIND_CARD_BYTE, m_txq[i]); n++;
            end
            m_tx_level = 0;
            m_awaiting = 1'b1; m_await_flush = 1'b1;
          end else begin
            m_tx_level = 0;
            schedule_delivery(1'b1, 1'b0);
          end
        end
      end
      OP_RXFC_WR: ;
      OP_CARD_BYTE: begin
        if (m_rx_level < RXD) begin
          m_rxq[m_rx_wr_idx] = it.data;
          m_rx_wr_idx = (m_rx_wr_idx + 1 >= RXD) ? 0 : m_rx_wr_idx + 1;
          m_rx_level++;
        end
      end
      OP_CARD_DONE: begin
        if (m_awaiting) begin
          m_awaiting = 1'b0;
          if (m_await_flush) schedule_delivery(1'b1, m_rx_level != m_snap);
          else schedule_delivery(1'b0, 1'b1);
        end
      end
      OP_CLOCK: begin
        en = it.data[0];
        if (en != m_clk_on) begin
          m_clk_on = en;
          if (!en) begin m_armed = 1'b0; m_left = 0; end
          else if (m_tx_pend || (!m_holding && m_rx_level != 0)) arm_char_timer();
        end
      end
      OP_TICK: begin
        if (m_armed) begin
          if (m_left > 1) m_left--;
          else begin
            m_armed = 1'b0; m_left = 0;
            n += char_timer_fire();
          end
        end
      end
      default: ;
    endcase
    if (n == 0) begin
      add_result(KIND_ACK, 8'h00);
    end
    r = expected_results.pop_back();
    r.last = 1'b1;
    expected_results.push_back(r);
  endfunction

  // Driver: hold the transaction until accepted, then advance the queue
  always @(posedge clk) begin
    item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_controller('{op: in_op, data: in_data});
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          in_op <= it.op;
          in_data <= it.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold_left <= 0;
    end else if (rx_hold && rx_hold_left == 0 && out_ready !== 1'b0) begin
      rx_hold_left <= 400;
      out_ready <= 1'b0;
    end else if (rx_hold_left > 1) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_hold_left == 1) rx_hold_left <= 0;
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d value=%02h", out_kind, out_value);
      end else begin
        e = expected_results.pop_front();
        if (out_kind !== e.kind || out_value !== e.value ||
            out_int_status !== e.status || out_last !== e.last) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k=%0d v=%02h s=%02h l=%0d got k=%0d v=%02h s=%02h l=%0d",
                     e.kind, e.value, e.status, e.last,
                     out_kind, out_value, out_int_status, out_last);
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted transaction or delivered result
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (!stim_done) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_ENABLED: m_en_cfg = val[0];
      REG_CARD:    m_card = val[0];
      REG_TICKS:   m_ticks = val[15:0];
      default: ;
    endcase
  endtask

  // Wait until the block is drained: nothing queued, nothing expected
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic void push_op(logic [3:0] op, logic [7:0] data);
    pending_items.push_back('{op: op, data: data});
  endfunction

  // A well-formed session: activate, exchange a few frames, read replies
  function automatic void push_session(int frames);
    int nb;
    push_op(OP_CLOCK, 8'h01);
    push_op(OP_CTRL_WR, 8'h00);
    push_op(OP_CTRL_WR, 8'h80 | 8'($urandom_range(127)));
    for (int i = 0; i < $urandom_range(3); i++) push_op(OP_CARD_BYTE, 8'($urandom));
    push_op(OP_CARD_DONE, 8'($urandom));
    for (int f = 0; f < frames; f++) begin
      push_op(OP_TXFC_WR, 8'($urandom_range(255, 1)));
      nb = ($urandom_range(9) == 0) ? 34 : $urandom_range(1, 6);
      for (int i = 0; i < nb; i++) push_op(OP_TX_WR, 8'($urandom));
      push_op(OP_TXFC_WR, 8'h00);
      for (int i = 0; i < $urandom_range(3); i++) push_op(OP_CARD_BYTE, 8'($urandom));
      push_op(OP_CARD_DONE, 8'($urandom));
      for (int i = 0; i < $urandom_range(2, 6); i++) begin
        case ($urandom_range(5))
          0, 1, 2: push_op(OP_TICK, 8'($urandom));
          3: push_op(OP_RX_RD, 8'($urandom));
          4: push_op(OP_COUNT_RD, 8'($urandom));
          default: push_op(OP_CTRL_RD, 8'($urandom));
        endcase
      end
    end
  endfunction

  function automatic void push_noise(int cnt);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(19) == 0) push_op(4'($urandom_range(15, 11)), 8'($urandom));
      else push_op(4'($urandom_range(10)), 8'($urandom));
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_op = OP_CTRL_RD; in_data = 8'h00;
    out_ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    mismatches = 0; failed = 1'b0; idle_pct = 37; rx_hold = 1'b0; stim_done = 1'b0;
    m_en_cfg = 1'b1; m_card = 1'b1; m_ticks = 16'd1;
    m_ctrl = '0; m_rx_rd_idx = 0; m_rx_wr_idx = 0; m_rx_level = 0; m_holding = 1'b0;
    m_irq = IRQ_NONE; m_tx_pend = 1'b0; m_tx_level = 0; m_txfc = '0;
    m_clk_on = 1'b0; m_armed = 1'b0; m_left = 0;
    m_awaiting = 1'b0; m_await_flush = 1'b0; m_snap = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unknown op, reads while idle, activation, flush, ticks
    push_op(4'd15, 8'hFF);
    push_op(OP_RX_RD, 8'h00);
    push_op(OP_CARD_DONE, 8'h00);
    push_op(OP_CLOCK, 8'h01);
    push_op(OP_CLOCK, 8'hFF);
    push_op(OP_CTRL_WR, 8'hFF);
    push_op(OP_CTRL_RD, 8'h00);
    push_op(OP_CARD_BYTE, 8'hFF);
    push_op(OP_CARD_BYTE, 8'h00);
    push_op(OP_CARD_DONE, 8'h00);
    push_op(OP_TICK, 8'h00);
    push_op(OP_COUNT_RD, 8'h00);
    push_op(OP_RX_RD, 8'h00);
    push_op(OP_TICK, 8'hFF);
    push_op(OP_RX_RD, 8'h00);
    push_op(OP_TXFC_WR, 8'h01);
    push_op(OP_TX_WR, 8'hFF);
    push_op(OP_TX_WR, 8'h00);
    push_op(OP_TXFC_WR, 8'h00);
    push_op(OP_CARD_DONE, 8'h00);
    push_op(OP_TICK, 8'h00);
    push_op(OP_RXFC_WR, 8'hA5);
    push_op(OP_CLOCK, 8'h00);
    push_op(OP_TICK, 8'h00);
    drain();

    // No card, long char time, then zero char time
    cfg_write(REG_CARD, 32'd0);
    cfg_write(REG_TICKS, 32'hFFFF);
    push_session(1);
    push_noise(8);
    drain();
    cfg_write(REG_TICKS, 32'd0);
    cfg_write(REG_CARD, 32'd1);
    push_session(2);
    // Fill the receive ring past its depth so a card byte gets dropped
    for (int i = 0; i < RXD + 4; i++) push_op(OP_CARD_BYTE, 8'($urandom));
    push_op(OP_CARD_DONE, 8'h00);
    drain();
    cfg_write(REG_ENABLED, 32'd0);
    push_session(1);
    push_noise(6);
    drain();
    cfg_write(REG_ENABLED, 32'd1);
    cfg_write(REG_TICKS, 32'd2);

    // Back pressure: the receiver stalls while the sender keeps offering
    rx_hold = 1'b1;
    push_session(2);
    while (pending_items.size() > 0) @(posedge clk);
    rx_hold = 1'b0;
    drain();

    // Random part; a stretch without idling in the middle
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 2) ? 0 : 37;
      cfg_write(REG_TICKS, 32'($urandom_range(1, 3)));
      cfg_write(REG_CARD, 32'($urandom_range(9) != 0));
      push_session($urandom_range(1, 2));
      push_noise(6);
      drain();
    end
    idle_pct = 37;
    stim_done = 1'b1;

    if (!failed && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
